FILE: src/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared types and constants for the path longest-prefix match block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpm_pkg;

  localparam int unsigned MaxEntriesDef   = 16;
  localparam int unsigned MaxPrefixLenDef = 64;

  localparam logic [7:0] SlashByte = 8'h2F;

  typedef enum logic [1:0] {
    OP_PREFIX_CHAR = 2'd0,
    OP_PREFIX_END  = 2'd1,
    OP_PATH_CHAR   = 2'd2,
    OP_PATH_END    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MS_MATCHING  = 2'd0,
    MS_FAILED    = 2'd1,
    MS_CONFIRMED = 2'd2
  } match_state_e;

  typedef enum logic [1:0] {
    CT_IDLE,
    CT_COMPARE,
    CT_REDUCE
  } ctrl_state_e;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic       wr_en;
    logic       cmp_en;
    logic       add_en;
    logic       add_failed;
    logic       clr;
    logic [7:0] char_byte;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/lpm_cell.sv
// ----------------------------------------------------------------------------
// lpm_cell
// One table entry: prefix storage, length, match state, and one link of the
// best-match chain.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_cell #(
  parameter int unsigned MaxEntries   = lpm_pkg::MaxEntriesDef,
  parameter int unsigned MaxPrefixLen = lpm_pkg::MaxPrefixLenDef,
  parameter int unsigned Idx          = 0,
  localparam int unsigned EW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1,
  localparam int unsigned AW = (MaxPrefixLen > 1) ? $clog2(MaxPrefixLen) : 1,
  localparam int unsigned LW = $clog2(MaxPrefixLen + 1),
  localparam int unsigned PW = $clog2(MaxPrefixLen + 2)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  lpm_pkg::cell_ctrl_t   ctrl_i,
  input  wire  [EW-1:0]         sel_i,
  input  wire  [AW-1:0]         wr_addr_i,
  input  wire  [LW-1:0]         add_len_i,
  input  wire  [PW-1:0]         path_pos_i,
  input  wire                   prev_found_i,
  input  wire  [EW-1:0]         prev_idx_i,
  input  wire  [LW-1:0]         prev_len_i,
  output logic                  best_found_o,
  output logic [EW-1:0]         best_idx_o,
  output logic [LW-1:0]         best_len_o
);
  import lpm_pkg::*;

  localparam logic [EW-1:0] MyIdx = EW'(Idx);

  logic [7:0]    mem_q [MaxPrefixLen];
  logic [7:0]    rdata_q;
  logic [LW-1:0] len_q;
  logic          valid_q;
  match_state_e  st_q, st_d;
  logic          selected;
  logic          hit;
  logic [PW-1:0] len_ext;

  assign selected = (sel_i == MyIdx);
  assign len_ext  = PW'(len_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && selected) begin
      mem_q[wr_addr_i] <= ctrl_i.char_byte;
    end
    rdata_q <= mem_q[path_pos_i[AW-1:0]];
  end

  always_comb begin
    st_d = st_q;
    if (ctrl_i.clr) begin
      st_d = MS_MATCHING;
    end else if (ctrl_i.add_en && selected) begin
      st_d = ctrl_i.add_failed ? MS_FAILED : MS_MATCHING;
    end else if (ctrl_i.cmp_en && valid_q && st_q == MS_MATCHING) begin
      if (path_pos_i < len_ext) begin
        if (rdata_q != ctrl_i.char_byte) st_d = MS_FAILED;
      end else if (path_pos_i == len_ext) begin
        st_d = (ctrl_i.char_byte == SlashByte) ? MS_CONFIRMED : MS_FAILED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= MS_MATCHING;
      valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ctrl_i.add_en && selected) valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.add_en && selected) len_q <= add_len_i;
  end

  // strict compare keeps the lower index on equal lengths
  assign hit = valid_q && (len_q != '0) &&
               ((st_q == MS_CONFIRMED) || (st_q == MS_MATCHING && path_pos_i == len_ext));

  always_ff @(posedge clk_i) begin
    if (hit && (len_q > prev_len_i)) begin
      best_found_o <= 1'b1;
      best_idx_o   <= MyIdx;
      best_len_o   <= len_q;
    end else begin
      best_found_o <= prev_found_i;
      best_idx_o   <= prev_idx_i;
      best_len_o   <= prev_len_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/path_longest_prefix_match_top.sv
// ----------------------------------------------------------------------------
// path_longest_prefix_match_top
// Longest-prefix match of streamed paths against a loaded prefix table.
// ----------------------------------------------------------------------------
// Usage: one input channel (opcode_i, char_byte_i) and one result channel,
// both valid/ready. Prefix characters and end-of-prefix requests load the
// table; path characters and end-of-path requests run a lookup. Only
// end-of-prefix and end-of-path requests produce a result.
// Timing: prefix characters and end of prefix are taken in the idle state; the
// load answer shows the cycle after the request. A path character passes
// through a compare state, needed by the registered read of each cell's
// prefix memory before the compare. End of path runs a reduce state while the
// best match ripples down the row of cells, one cell per cycle, and then waits
// for a free output slot to give its answer.
// Each cell holds one entry with its own MAX_PREFIX_LEN x 8 memory.
// Reset empties the table and clears load and lookup state; prefix storage
// itself is not cleared and needs no clearing pass.
// A result waits in an output register; while it is held and not taken the
// block accepts no request, and a finished lookup waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module path_longest_prefix_match_top #(
  parameter int unsigned MaxEntries   = lpm_pkg::MaxEntriesDef,
  parameter int unsigned MaxPrefixLen = lpm_pkg::MaxPrefixLenDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [1:0] opcode_i,
  input  wire  [7:0] char_byte_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic       result_kind_o,
  output logic [1:0] status_o,
  output logic       found_o,
  output logic [3:0] entry_index_o,
  output logic [6:0] match_length_o
);
  import lpm_pkg::*;

  localparam int unsigned EW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CW = $clog2(MaxEntries + 1);
  localparam int unsigned AW = (MaxPrefixLen > 1) ? $clog2(MaxPrefixLen) : 1;
  localparam int unsigned LW = $clog2(MaxPrefixLen + 1);
  localparam int unsigned PW = $clog2(MaxPrefixLen + 2);
  localparam logic [CW-1:0] FullCount = CW'(MaxEntries);
  localparam logic [LW-1:0] MaxLen    = LW'(MaxPrefixLen);
  localparam logic [PW-1:0] PosSat    = PW'(MaxPrefixLen + 1);
  localparam logic [EW-1:0] LastCnt   = EW'(MaxEntries - 1);

  ctrl_state_e   state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [LW-1:0] load_pos_q, load_pos_d;
  logic [1:0]    fault_q, fault_d;
  logic [PW-1:0] path_pos_q, path_pos_d;
  logic [EW-1:0] red_cnt_q, red_cnt_d;
  logic [7:0]    char_q, char_d;
  cell_ctrl_t    ctrl;

  logic          out_valid_q, out_valid_d;
  logic          kind_q, kind_d;
  logic [1:0]    status_q, status_d;
  logic          found_q, found_d;
  logic [3:0]    idx_q, idx_d;
  logic [6:0]    mlen_q, mlen_d;

  logic          accept;
  logic          slot_free;
  logic          full;
  opcode_e       op;

  logic          ch_found [MaxEntries+1];
  logic [EW-1:0] ch_idx   [MaxEntries+1];
  logic [LW-1:0] ch_len   [MaxEntries+1];

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == CT_IDLE) && slot_free;
  assign accept = in_valid_i && in_ready_o;
  assign op = opcode_e'(opcode_i);
  assign full = (count_q >= FullCount);

  assign ch_found[0] = 1'b0;
  assign ch_idx[0]   = '0;
  assign ch_len[0]   = '0;

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    lpm_cell #(
      .MaxEntries  (MaxEntries),
      .MaxPrefixLen(MaxPrefixLen),
      .Idx         (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .sel_i       (count_q[EW-1:0]),
      .wr_addr_i   (load_pos_q[AW-1:0]),
      .add_len_i   (load_pos_q),
      .path_pos_i  (path_pos_q),
      .prev_found_i(ch_found[g]),
      .prev_idx_i  (ch_idx[g]),
      .prev_len_i  (ch_len[g]),
      .best_found_o(ch_found[g+1]),
      .best_idx_o  (ch_idx[g+1]),
      .best_len_o  (ch_len[g+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    load_pos_d  = load_pos_q;
    fault_d     = fault_q;
    path_pos_d  = path_pos_q;
    red_cnt_d   = red_cnt_q;
    char_d      = char_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    status_d    = status_q;
    found_d     = found_q;
    idx_d       = idx_q;
    mlen_d      = mlen_q;
    ctrl        = '0;
    ctrl.char_byte = char_byte_i;

    case (state_q)
      CT_IDLE: begin
        if (accept) begin
          case (op)
            OP_PREFIX_CHAR: begin
              if (full) begin
                fault_d = STATUS_FULL;
              end else if (load_pos_q >= MaxLen) begin
                if (fault_q == STATUS_OK) fault_d = STATUS_TOO_LONG;
              end else begin
                ctrl.wr_en = 1'b1;
                load_pos_d = load_pos_q + 1'b1;
              end
            end
            OP_PREFIX_END: begin
              if (full) begin
                status_d = STATUS_FULL;
              end else if (fault_q != STATUS_OK) begin
                status_d = fault_q;
              end else begin
                status_d        = STATUS_OK;
                ctrl.add_en     = 1'b1;
                ctrl.add_failed = (path_pos_q != '0);
                count_d         = count_q + 1'b1;
              end
              load_pos_d  = '0;
              fault_d     = STATUS_OK;
              out_valid_d = 1'b1;
              kind_d      = 1'b0;
              found_d     = 1'b0;
              idx_d       = '0;
              mlen_d      = '0;
            end
            OP_PATH_CHAR: begin
              char_d  = char_byte_i;
              state_d = CT_COMPARE;
            end
            default: begin
              red_cnt_d = '0;
              state_d   = CT_REDUCE;
            end
          endcase
        end
      end
      CT_COMPARE: begin
        ctrl.cmp_en    = 1'b1;
        ctrl.char_byte = char_q;
        if (path_pos_q < PosSat) path_pos_d = path_pos_q + 1'b1;
        state_d = CT_IDLE;
      end
      CT_REDUCE: begin
        if (red_cnt_q != LastCnt) begin
          red_cnt_d = red_cnt_q + 1'b1;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = 1'b1;
          status_d    = STATUS_OK;
          found_d     = ch_found[MaxEntries];
          idx_d       = 4'(32'(ch_idx[MaxEntries]));
          mlen_d      = 7'(32'(ch_len[MaxEntries]));
          ctrl.clr    = 1'b1;
          path_pos_d  = '0;
          state_d     = CT_IDLE;
        end
      end
      default: state_d = CT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CT_IDLE;
      count_q     <= '0;
      load_pos_q  <= '0;
      fault_q     <= STATUS_OK;
      path_pos_q  <= '0;
      red_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      load_pos_q  <= load_pos_d;
      fault_q     <= fault_d;
      path_pos_q  <= path_pos_d;
      red_cnt_q   <= red_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    kind_q   <= kind_d;
    status_q <= status_d;
    found_q  <= found_d;
    idx_q    <= idx_d;
    mlen_q   <= mlen_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign entry_index_o  = idx_q;
  assign match_length_o = mlen_q;

  // a request is only taken while the sequencer is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == CT_IDLE)
    else $error("request taken while sequencer busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    path_pos_q <= PosSat)
    else $error("path position beyond saturation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (entry_index_o == '0 && match_length_o == '0))
    else $error("miss result carries index or length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !result_kind_o) |-> !found_o)
    else $error("load answer reports a match");

  // a finished lookup leaves no path state behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CT_REDUCE && state_d == CT_IDLE) |=> path_pos_q == '0)
    else $error("path position not cleared after lookup");

endmodule

`default_nettype wire
